// ===== rtl/nvrgb_pkg.sv =====
// Shared types and constants for the semi-planar YUV to RGB888 converter.
// Used by the front, queue, back and top level modules; no dependencies.
package nvrgb_pkg;

   // Configuration register indexes.
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   // Configuration register widths and reset values.
   localparam int                  CSR_W            = 13;
   localparam logic [CSR_W-1:0]    FRAME_WIDTH_RST  = 13'd640;
   localparam logic [CSR_W-1:0]    FRAME_HEIGHT_RST = 13'd480;

   // Pixel arithmetic constants.
   localparam int                  SUM_W     = 21;
   localparam logic [7:0]          LUMA_OFS  = 8'd16;
   localparam logic signed [SUM_W-1:0] K_Y   = 21'sd1192;
   localparam logic signed [SUM_W-1:0] K_RV  = 21'sd1634;
   localparam logic signed [SUM_W-1:0] K_GV  = 21'sd833;
   localparam logic signed [SUM_W-1:0] K_GU  = 21'sd400;
   localparam logic signed [SUM_W-1:0] K_BU  = 21'sd2066;
   localparam logic signed [SUM_W-1:0] CH_MAX = 21'sd262143;
   localparam int                  CH_SHIFT  = 10;

   // One classified pixel as it travels from front to back.
   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma_v;
      logic [7:0] chroma_u;
      logic       line_end;
      logic       frame_end;
   } pixel_type;

endpackage

// ===== rtl/nvrgb_front.sv =====
// Front end: configuration registers, column/row counters and chroma pairing.
// Depends on nvrgb_pkg for register indexes and the pixel_type struct.
module nvrgb_front #(
   parameter int MAX_LINE_WIDTH = 4096,
   parameter int MAX_LINE_COUNT = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic                        csr_addr,
   input  logic [nvrgb_pkg::CSR_W-1:0] csr_wdata,
   input  logic                        accept,
   input  logic [7:0]                  luma,
   input  logic [7:0]                  chroma_first,
   input  logic [7:0]                  chroma_second,
   output nvrgb_pkg::pixel_type        pixel
);

   localparam int CW = $clog2(MAX_LINE_WIDTH);
   localparam int RW = $clog2(MAX_LINE_COUNT);

   logic [nvrgb_pkg::CSR_W-1:0] frame_width_ff, frame_width_in;
   logic [nvrgb_pkg::CSR_W-1:0] frame_height_ff, frame_height_in;
   logic [CW-1:0] column_ff, column_in;
   logic [RW-1:0] row_ff, row_in;
   logic [7:0]    held_v_ff, held_v_in;
   logic [7:0]    held_u_ff, held_u_in;
   logic [31:0]   fw_ext, fh_ext;
   logic [CW-1:0] col_last;
   logic [RW-1:0] row_last;
   logic          even_col, at_line_end, at_frame_end;

   // Configuration writes.
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_we) begin
         case (csr_addr)
            nvrgb_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            nvrgb_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Last column and last row index; zero acts as one, oversize is capped.
   always_comb begin
      fw_ext = 32'(frame_width_ff);
      fh_ext = 32'(frame_height_ff);
      if (fw_ext == 32'd0)
         col_last = '0;
      else if (fw_ext > 32'(MAX_LINE_WIDTH))
         col_last = CW'(MAX_LINE_WIDTH - 1);
      else
         col_last = CW'(fw_ext - 32'd1);
      if (fh_ext == 32'd0)
         row_last = '0;
      else if (fh_ext > 32'(MAX_LINE_COUNT))
         row_last = RW'(MAX_LINE_COUNT - 1);
      else
         row_last = RW'(fh_ext - 32'd1);
   end

   assign even_col     = ~column_ff[0];
   assign at_line_end  = (column_ff >= col_last);
   assign at_frame_end = at_line_end && (row_ff >= row_last);

   // Counter and chroma hold updates for an accepted item.
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      held_v_in = held_v_ff;
      held_u_in = held_u_ff;
      if (accept) begin
         if (even_col) begin
            held_v_in = chroma_first;
            held_u_in = chroma_second;
         end
         if (at_line_end) begin
            column_in = '0;
            row_in    = at_frame_end ? '0 : row_ff + RW'(1);
         end else begin
            column_in = column_ff + CW'(1);
         end
      end
   end

   // Classified pixel for the queue.
   always_comb begin
      pixel.luma      = luma;
      pixel.chroma_v  = even_col ? chroma_first  : held_v_ff;
      pixel.chroma_u  = even_col ? chroma_second : held_u_ff;
      pixel.line_end  = at_line_end;
      pixel.frame_end = at_frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= nvrgb_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= nvrgb_pkg::FRAME_HEIGHT_RST;
         column_ff       <= '0;
         row_ff          <= '0;
         held_v_ff       <= '0;
         held_u_ff       <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         column_ff       <= column_in;
         row_ff          <= row_in;
         held_v_ff       <= held_v_in;
         held_u_ff       <= held_u_in;
      end
   end

endmodule

// ===== rtl/nvrgb_queue.sv =====
// Two-entry queue between the front end and the conversion back end.
// Depends on nvrgb_pkg for the pixel_type struct.
module nvrgb_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  nvrgb_pkg::pixel_type push_data,
   output logic                 not_full,
   input  logic                 pop,
   output logic                 not_empty,
   output nvrgb_pkg::pixel_type pop_data
);

   nvrgb_pkg::pixel_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign not_full  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   // Pointer and fill count update; push and pop may share a cycle.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/nvrgb_back.sv =====
// Back end: two-stage fixed-point YUV to RGB pipeline ending in the output register.
// Depends on nvrgb_pkg for the coefficients and the pixel_type struct.
module nvrgb_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  nvrgb_pkg::pixel_type in_pixel,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [23:0]          out_rgb,
   output logic                 out_line_end,
   output logic                 out_frame_end
);

   localparam int SW = nvrgb_pkg::SUM_W;

   // Stage 1: products.
   logic                 s1_valid_ff, s1_valid_in;
   logic signed [SW-1:0] base_ff, rv_ff, gv_ff, gu_ff, bu_ff;
   logic                 s1_le_ff, s1_fe_ff;
   // Stage 2: output register.
   logic                 s2_valid_ff, s2_valid_in;
   logic [23:0]          rgb_ff;
   logic                 s2_le_ff, s2_fe_ff;

   logic                 s1_ready, s2_ready;
   logic [7:0]           y_clip;
   logic signed [7:0]    v_s, u_s;
   logic signed [SW-1:0] r_sum, g_sum, b_sum;

   // Clamp a channel to 0..262143 and keep bits 17..10.
   function automatic logic [7:0] chan(input logic signed [SW-1:0] x);
      logic [7:0] res;
      if (x < 0)
         res = 8'd0;
      else if (x > nvrgb_pkg::CH_MAX)
         res = 8'hFF;
      else
         res = x[nvrgb_pkg::CH_SHIFT +: 8];
      return res;
   endfunction

   assign s2_ready = ~s2_valid_ff | out_ready;
   assign s1_ready = ~s1_valid_ff | s2_ready;
   assign in_ready = s1_ready;

   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   // Luma minus 16 clamped at zero; chroma minus 128 is the byte with its top bit flipped.
   always_comb begin
      y_clip = (in_pixel.luma < nvrgb_pkg::LUMA_OFS) ? 8'd0
             : in_pixel.luma - nvrgb_pkg::LUMA_OFS;
      v_s = $signed({~in_pixel.chroma_v[7], in_pixel.chroma_v[6:0]});
      u_s = $signed({~in_pixel.chroma_u[7], in_pixel.chroma_u[6:0]});
   end

   // Channel sums from the registered products.
   always_comb begin
      r_sum = base_ff + rv_ff;
      g_sum = base_ff - gv_ff - gu_ff;
      b_sum = base_ff + bu_ff;
   end

   // Stage 1 payload.
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         base_ff  <= nvrgb_pkg::K_Y * $signed({{(SW-8){1'b0}}, y_clip});
         rv_ff    <= nvrgb_pkg::K_RV * SW'(v_s);
         gv_ff    <= nvrgb_pkg::K_GV * SW'(v_s);
         gu_ff    <= nvrgb_pkg::K_GU * SW'(u_s);
         bu_ff    <= nvrgb_pkg::K_BU * SW'(u_s);
         s1_le_ff <= in_pixel.line_end;
         s1_fe_ff <= in_pixel.frame_end;
      end
   end

   // Stage 2 payload: clamp, shift and pack.
   always_ff @(posedge clock) begin
      if (s2_ready) begin
         rgb_ff   <= {chan(r_sum), chan(g_sum), chan(b_sum)};
         s2_le_ff <= s1_le_ff;
         s2_fe_ff <= s1_fe_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   assign out_valid     = s2_valid_ff;
   assign out_rgb       = rgb_ff;
   assign out_line_end  = s2_le_ff;
   assign out_frame_end = s2_fe_ff;

endmodule

// ===== rtl/nv_semiplanar_to_rgb_converter.sv =====
// Semi-planar YUV 4:2:0 to packed RGB888 converter, top level.
// An accepted item passes the queue, the product stage and the output register.
// Throughput: one item per cycle unless the output stalls; the two-entry queue and
// the two product and output pipeline stages let input and output stall independently.
// Reset (synchronous, active high) clears counters, held chroma, queue and valid
// flags and loads frame_width 640 and frame_height 480. Depends on nvrgb_pkg.
module nv_semiplanar_to_rgb_converter #(
   parameter int MAX_LINE_WIDTH = 4096,
   parameter int MAX_LINE_COUNT = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   // Input item stream.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [23:0]                 req_tdata,   // luma, chroma_first, chroma_second
   // Result item stream.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [23:0]                 rsp_tdata,   // pixel_rgb
   output logic                        rsp_tlast,   // line_end
   output logic [0:0]                  rsp_tuser,   // frame_end
   // Configuration write port.
   input  logic                        csr_we,
   input  logic                        csr_addr,
   input  logic [nvrgb_pkg::CSR_W-1:0] csr_wdata
);

   nvrgb_pkg::pixel_type front_pixel, queue_pixel;
   logic req_accept, q_not_full, q_not_empty, back_ready;
   logic out_le, out_fe;

   assign req_tready = q_not_full;
   assign req_accept = req_tvalid & q_not_full;

   // Front end: counters, chroma pairing and line/frame flags.
   nvrgb_front #(
      .MAX_LINE_WIDTH(MAX_LINE_WIDTH),
      .MAX_LINE_COUNT(MAX_LINE_COUNT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .accept       (req_accept),
      .luma         (req_tdata[7:0]),
      .chroma_first (req_tdata[15:8]),
      .chroma_second(req_tdata[23:16]),
      .pixel        (front_pixel)
   );

   // Decoupling queue.
   nvrgb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_accept),
      .push_data(front_pixel),
      .not_full (q_not_full),
      .pop      (q_not_empty & back_ready),
      .not_empty(q_not_empty),
      .pop_data (queue_pixel)
   );

   // Back end: color conversion pipeline and output register.
   nvrgb_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (q_not_empty),
      .in_ready     (back_ready),
      .in_pixel     (queue_pixel),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_rgb      (rsp_tdata),
      .out_line_end (out_le),
      .out_frame_end(out_fe)
   );

   assign rsp_tlast    = out_le;
   assign rsp_tuser[0] = out_fe;

endmodule
